@@ rtl/ptw_pkg.sv @@
`timescale 1ns / 1ps

package ptw_pkg;

    // Table memory geometry
    localparam int TABLE_FRAMES      = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int MEM_WORDS         = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int FRAME_W           = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int ADDR_W            = FRAME_W + IDX_W;
    localparam int ENTRY_W           = 64;
    localparam int ROOT_W            = 6;
    localparam int PAGE_SHIFT        = 12;
    localparam logic [PAGE_SHIFT-1:0] OFFSET_MASK = 12'hFFF;

    localparam logic [1:0] LEAF_LEVEL = 2'd3;

    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_TRANSLATE = 2'd1,
        KIND_UNMAP     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind         kind;
        logic [63:0]   vaddr;
        logic [14:0]   entry_index;
        logic [63:0]   entry_value;
    } t_ptw_req;

    typedef struct packed {
        logic [63:0]   phys_addr;
        logic          mapped;
        logic          out_of_range;
    } t_ptw_rsp;

    // Table index of one walk level: bits 47:39, 38:30, 29:21, 20:12
    function automatic logic [IDX_W-1:0] level_index(input logic [63:0] va,
                                                      input logic [1:0]  lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/ptw_ram.sv @@
`timescale 1ns / 1ps

module ptw_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ptw_walk.sv @@
`timescale 1ns / 1ps

module ptw_walk
    import ptw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_ptw_req           i_cmd,
    input  logic [ROOT_W-1:0]  i_root,
    output logic               o_busy,
    output logic               o_done,
    output t_ptw_rsp           o_res,
    output logic               o_mem_en,
    output logic               o_mem_we,
    output logic [ADDR_W-1:0]  o_mem_addr,
    output logic [ENTRY_W-1:0] o_mem_wdata,
    input  logic [ENTRY_W-1:0] i_mem_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK
    } t_state;

    t_state             r_state;
    t_ptw_req           r_cmd;
    logic [1:0]         r_level;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_done;
    t_ptw_rsp           r_res;

    logic [63:0]        root_ext;
    logic               root_null;
    logic               root_oor;
    logic [51:0]        ent_frame;
    logic               ent_present;
    logic               ent_null;
    logic               ent_oor;
    logic               wr_ok;

    assign root_ext    = 64'(i_root);
    assign root_null   = (i_root == '0);
    assign root_oor    = (root_ext >= 64'(TABLE_FRAMES));
    assign ent_frame   = i_mem_rdata[63:PAGE_SHIFT];
    assign ent_present = i_mem_rdata[0];
    assign ent_null    = (ent_frame == '0);
    assign ent_oor     = (ent_frame >= 52'(TABLE_FRAMES));
    assign wr_ok       = (64'(r_cmd.entry_index) < 64'(MEM_WORDS));

    // Single memory port: clear sweep, entry write, level reads, leaf clear
    always_comb begin
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_clr;
        o_mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_en = 1'b1;
                o_mem_we = 1'b1;
            end
            S_START: begin
                case (r_cmd.kind) inside
                    KIND_WRITE: begin
                        o_mem_en    = wr_ok;
                        o_mem_we    = 1'b1;
                        o_mem_addr  = ADDR_W'(r_cmd.entry_index);
                        o_mem_wdata = r_cmd.entry_value;
                    end
                    KIND_TRANSLATE, KIND_UNMAP: begin
                        o_mem_en   = !root_null && !root_oor;
                        o_mem_addr = {FRAME_W'(root_ext), level_index(r_cmd.vaddr, 2'd0)};
                    end
                    default: begin
                        o_mem_en = 1'b0;
                    end
                endcase
            end
            S_WALK: begin
                if (r_level != LEAF_LEVEL) begin
                    o_mem_en   = ent_present && !ent_null && !ent_oor;
                    o_mem_addr = {i_mem_rdata[PAGE_SHIFT +: FRAME_W],
                                  level_index(r_cmd.vaddr, r_level + 2'd1)};
                end else if (r_cmd.kind == KIND_UNMAP) begin
                    o_mem_en   = 1'b1;
                    o_mem_we   = 1'b1;
                    o_mem_addr = r_addr;
                end
            end
            default: begin
                o_mem_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_level <= '0;
        end else begin
            r_done <= 1'b0;
            if (o_mem_en && !o_mem_we) begin
                r_addr <= o_mem_addr;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_level <= '0;
                    r_res   <= '0;
                    case (r_cmd.kind) inside
                        KIND_TRANSLATE, KIND_UNMAP: begin
                            if (root_null) begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else if (root_oor) begin
                                r_res.out_of_range <= 1'b1;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_WALK: begin
                    if (r_level != LEAF_LEVEL) begin
                        if (!ent_present || ent_null) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (ent_oor) begin
                            r_res.out_of_range <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_level <= r_level + 2'd1;
                        end
                    end else begin
                        if (r_cmd.kind == KIND_TRANSLATE) begin
                            if (ent_present) begin
                                r_res.mapped    <= 1'b1;
                                r_res.phys_addr <= {i_mem_rdata[63:PAGE_SHIFT],
                                                    r_cmd.vaddr[PAGE_SHIFT-1:0] & OFFSET_MASK};
                            end
                        end else begin
                            r_res.mapped <= ent_present;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/four_level_page_table_walker_top.sv @@
`timescale 1ns / 1ps

// Channel   | Handshake                         | Beat
// ----------+-----------------------------------+-------------------------------
// command   | start high while busy low         | i_cmd (kind, address, entry)
// result    | o_done high for one cycle         | o_res (phys_addr, flags)
// config    | i_cfg_valid and o_cfg_ready high  | i_cfg_data (root table frame)
//
// A write beat is accepted, then written to table memory; a translate or unmap
// beat is accepted, its root is checked, then it reads one level at a time on
// the single table-memory port, whose registered read sets the walk pace.
// The registered result strobe follows in the next cycle; a new command may be taken then.
// After reset all MEM_WORDS words of table memory are swept to zero
// (32768 at 64 frames); busy stays high until the sweep ends.
// The receiver cannot stall: each result beat is shown exactly once.

module four_level_page_table_walker_top
    import ptw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_ptw_req          i_cmd,
    output logic              o_done,
    output t_ptw_rsp          o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ROOT_W-1:0] i_cfg_data
);

    logic [ROOT_W-1:0]  r_root;
    logic               walk_busy;
    logic               mem_en;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    // Root frame register; always writable; software is to write it while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_valid) begin
            r_root <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Sequencer: clear sweep, command decode and level-by-level walk
    ptw_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !walk_busy),
        .i_cmd       (i_cmd),
        .i_root      (r_root),
        .o_busy      (walk_busy),
        .o_done      (o_done),
        .o_res       (o_res),
        .o_mem_en    (mem_en),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    // Table memory, one port, registered read
    ptw_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MEM_WORDS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign busy = walk_busy;

endmodule

@@ rtl/ptw_checker.sv @@
`timescale 1ns / 1ps

module ptw_checker
    import ptw_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_ptw_req i_cmd,
    input logic     o_done,
    input t_ptw_rsp o_res
);

    // Reset starts the clearing sweep, so the block reads busy
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    // An accepted command keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // One result per command: strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A walk that hit a frame beyond memory never reports a mapping
    a_oor_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.out_of_range) |-> (!o_res.mapped && o_res.phys_addr == '0))
        else $error("out_of_range result carries a mapping");

    // A nonzero address comes only from a completed translation
    a_phys_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.phys_addr != '0) |-> o_res.mapped)
        else $error("physical address without mapped flag");

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (.*);
